// ----- rtl/swnn_pkg.sv -----
// ---------------------------------------------------------------------------
// swnn_pkg: shared types and constants
// Payload structs, operation and status codes, and the controller/datapath
// command and status bundles for the simplex weight and neighbor block.
// ---------------------------------------------------------------------------
package swnn_pkg;

  // default sizing
  localparam int MAX_VECTORS_DEF    = 256;
  localparam int MAX_OBJECTIVES_DEF = 8;
  localparam int MAX_NEIGHBORS_DEF  = 64;

  // fixed field widths
  localparam int WGT_W      = 16;
  localparam int DIG_W      = 6;
  localparam int SCL_W      = 12;
  localparam int SQ_W       = 32;
  localparam int POP_W      = 9;
  localparam int OBJ_CFG_W  = 4;
  localparam int DIV_W      = 6;
  localparam int NBR_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int TOT_W      = 10;
  localparam int DIST_OUT_W = 35;

  // lattice count saturates here, above any population value
  localparam logic [TOT_W-1:0] TOT_LIMIT = 10'd512;

  // register reset values
  localparam logic [POP_W-1:0]     POP_RST   = 9'd91;
  localparam logic [OBJ_CFG_W-1:0] OBJ_RST   = 4'd3;
  localparam logic [DIV_W-1:0]     OUTER_RST = 6'd12;
  localparam logic [DIV_W-1:0]     INNER_RST = 6'd0;
  localparam logic [NBR_W-1:0]     NBR_RST   = 7'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POPULATION = 3'd0,
    CFG_OBJECTIVES = 3'd1,
    CFG_OUTER      = 3'd2,
    CFG_INNER      = 3'd3,
    CFG_NEIGHBORS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_BUILD     = 2'd0,
    OP_READ      = 2'd1,
    OP_NEIGHBORS = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISMATCH = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_UNBUILT  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    EM_NONE  = 3'd0,
    EM_BUILD = 3'd1,
    EM_ERR   = 3'd2,
    EM_READ  = 3'd3,
    EM_NEIGH = 3'd4
  } emit_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] vector_index;
    logic [2:0] objective_index;
  } in_item_t;

  typedef struct packed {
    stat_t                 status;
    logic [15:0]           weight_numerator;
    logic [15:0]           weight_denominator;
    logic [7:0]            neighbor_index;
    logic [DIST_OUT_W-1:0] distance_squared;
    logic                  last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETTLE,
    S_DISPATCH,
    S_B_INIT,
    S_B_WRITE,
    S_B_STEP,
    S_B_INNER,
    S_B_DONE,
    S_RD_ISSUE,
    S_RD_EMIT,
    S_ERR_EMIT,
    S_Q_ISSUE,
    S_Q_LOAD,
    S_D_ISSUE,
    S_D_SQ,
    S_D_ACC,
    S_S_ISSUE,
    S_S_CMP,
    S_S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic  latch;
    logic  clr;
    logic  b_init;
    logic  b_write;
    logic  b_step;
    logic  b_inner;
    logic  commit;
    logic  rd_vi;
    logic  q_issue;
    logic  q_load;
    logic  d_issue;
    logic  d_sq;
    logic  d_acc;
    logic  s_issue;
    logic  s_cmp;
    logic  s_next;
    emit_t emit;
  } ctl_cmd_t;

  typedef struct packed {
    op_t   op;
    stat_t err;
    logic  wr_en;
    logic  c_last;
    logic  j_last;
    logic  k_last;
    logic  layer_done;
    logic  tot_full;
    logic  inner_next;
    logic  out_free;
  } ctl_sts_t;

endpackage

// ----- rtl/simplex_weights_nearest_neighbors.sv -----
// ---------------------------------------------------------------------------
// simplex_weights_nearest_neighbors: lattice weights with neighbor query
// Handles error, read, build and neighbor-query items. A build stores W
// vectors and counts S lattice points past the cap, W+S at most 512; a query
// ranks N stored vectors and returns n neighbors; result stalls hold the
// sequence. One item at a time, the next accepted the cycle after the last
// beat issues. Reset: sync, no clears.
// ---------------------------------------------------------------------------
module simplex_weights_nearest_neighbors #(
  parameter int MAX_VECTORS    = swnn_pkg::MAX_VECTORS_DEF,
  parameter int MAX_OBJECTIVES = swnn_pkg::MAX_OBJECTIVES_DEF,
  parameter int MAX_NEIGHBORS  = swnn_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [swnn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swnn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swnn_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swnn_pkg::out_item_t             out_data
);

  import swnn_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  swnn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  swnn_dp #(
    .MAX_VECTORS    (MAX_VECTORS),
    .MAX_OBJECTIVES (MAX_OBJECTIVES),
    .MAX_NEIGHBORS  (MAX_NEIGHBORS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/swnn_ram.sv -----
// ---------------------------------------------------------------------------
// swnn_ram: generic simple dual-port memory
// One write port and one read port with registered, enabled read data.
// ---------------------------------------------------------------------------
module swnn_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/swnn_dp.sv -----
// ---------------------------------------------------------------------------
// swnn_dp: datapath
// Configuration registers, lattice digit enumerator, weight and distance
// memories, squared-distance accumulator, best-candidate search and the
// output register.
// ---------------------------------------------------------------------------
module swnn_dp #(
  parameter int MAX_VECTORS    = swnn_pkg::MAX_VECTORS_DEF,
  parameter int MAX_OBJECTIVES = swnn_pkg::MAX_OBJECTIVES_DEF,
  parameter int MAX_NEIGHBORS  = swnn_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swnn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swnn_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  swnn_pkg::in_item_t                  in_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output swnn_pkg::out_item_t                 out_data,
  input  swnn_pkg::ctl_cmd_t                  cmd,
  output swnn_pkg::ctl_sts_t                  sts
);

  import swnn_pkg::*;

  localparam int VEC_W  = $clog2(MAX_VECTORS);
  localparam int CNT_W  = $clog2(MAX_VECTORS + 1);
  localparam int OBJ_W  = $clog2(MAX_OBJECTIVES);
  localparam int M_W    = $clog2(MAX_OBJECTIVES + 1);
  localparam int ADDR_W = $clog2(MAX_VECTORS * MAX_OBJECTIVES);
  localparam int KW     = $clog2(MAX_NEIGHBORS + 1);
  localparam int NW     = (CNT_W > KW) ? CNT_W : KW;
  localparam int DW     = SQ_W + $clog2(MAX_OBJECTIVES);
  localparam int DEN_W  = 2 * DIV_W + M_W + 1;
  localparam int WV_W   = DIG_W + SCL_W;

  // configuration registers
  logic [POP_W-1:0]     pop_r;
  logic [OBJ_CFG_W-1:0] obj_r;
  logic [DIV_W-1:0]     outer_r;
  logic [DIV_W-1:0]     inner_r;
  logic [NBR_W-1:0]     nbr_r;

  // build results
  logic             built_r;
  logic [CNT_W-1:0] bc_r;

  // latched item
  in_item_t item_r;

  // derived constants
  logic [2*DIV_W-1:0] p1_r;
  logic [DEN_W-1:0]   den_r;
  logic [SCL_W-1:0]   s_out_r;
  logic [SCL_W-1:0]   s_in_r;
  logic [SCL_W-1:0]   off_r;

  // enumerator
  logic [DIG_W-1:0] dig_r   [MAX_OBJECTIVES];
  logic [DIG_W-1:0] dig_nxt [MAX_OBJECTIVES];
  logic             is_inner_r;
  logic [TOT_W-1:0] tot_r;
  logic [CNT_W-1:0] vcnt_r;

  // counters
  logic [OBJ_W-1:0] c_r;
  logic [VEC_W-1:0] j_r;
  logic [KW-1:0]    k_r;

  // distance and search
  logic [WGT_W-1:0] qv_r [MAX_OBJECTIVES];
  logic [SQ_W-1:0]  sq_r;
  logic [DW-1:0]    acc_r;
  logic             found_r;
  logic [DW-1:0]    bd_r;
  logic [VEC_W-1:0] bi_r;
  logic [DW-1:0]    pd_r;
  logic [VEC_W-1:0] pi_r;

  // output register
  logic      out_valid_r;
  out_item_t out_r;

  // combinational helpers
  logic [M_W-1:0]    m_eff;
  logic [DIV_W-1:0]  outer_eff;
  logic [DIV_W-1:0]  in_eff;
  logic [CNT_W-1:0]  cap;
  logic              pop_bad;
  logic [KW-1:0]     want;
  logic [NW-1:0]     n_cnt;
  logic              wr_en;
  logic              c_last;
  logic              j_last;
  logic              k_last;
  logic              lay_done;
  logic [OBJ_W-1:0]  fi;
  logic [DIG_W-1:0]  tval;
  stat_t             err;
  logic              mismatch;
  logic              out_free;
  logic [ADDR_W-1:0] vi_base;
  logic [ADDR_W-1:0] w_waddr;
  logic [ADDR_W-1:0] w_raddr;
  logic              w_re;
  logic              w_we;
  logic [WGT_W-1:0]  w_wdata;
  logic [WGT_W-1:0]  w_rdata;
  logic [WGT_W-1:0]  absd;
  logic [DW-1:0]     acc_sum;
  logic [DW-1:0]     d_rdata;
  logic              after;
  out_item_t         emit_data;

  // effective register values
  always_comb begin
    if (obj_r < 4'd2) begin
      m_eff = M_W'(2);
    end else if ({1'b0, obj_r} > 5'(MAX_OBJECTIVES)) begin
      m_eff = M_W'(MAX_OBJECTIVES);
    end else begin
      m_eff = M_W'(obj_r);
    end
    outer_eff = (outer_r == '0) ? DIV_W'(1) : outer_r;
    in_eff    = (inner_r == '0) ? DIV_W'(1) : inner_r;
    pop_bad   = (pop_r == '0) || ({2'b00, pop_r} > 11'(MAX_VECTORS));
    if (pop_r == '0) begin
      cap = CNT_W'(1);
    end else if ({2'b00, pop_r} > 11'(MAX_VECTORS)) begin
      cap = CNT_W'(MAX_VECTORS);
    end else begin
      cap = CNT_W'(pop_r);
    end
    if (nbr_r == '0) begin
      want = KW'(1);
    end else if ({1'b0, nbr_r} > 8'(MAX_NEIGHBORS)) begin
      want = KW'(MAX_NEIGHBORS);
    end else begin
      want = KW'(nbr_r);
    end
    n_cnt = (NW'(want) < NW'(bc_r)) ? NW'(want) : NW'(bc_r);
  end

  // loop end flags
  assign wr_en  = vcnt_r < cap;
  assign c_last = (M_W'(c_r) + M_W'(1)) == m_eff;
  assign j_last = (CNT_W'(j_r) + CNT_W'(1)) == bc_r;
  assign k_last = (NW'(k_r) + NW'(1)) == n_cnt;

  // digit counter step: lowest nonzero digit moves one unit up
  always_comb begin
    fi = '0;
    for (int i = MAX_OBJECTIVES - 1; i >= 0; i--) begin
      if ((M_W'(i) < m_eff) && (dig_r[i] != '0)) begin
        fi = OBJ_W'(i);
      end
    end
    lay_done = (M_W'(fi) + M_W'(1)) >= m_eff;
    tval     = dig_r[fi];
    for (int i = 0; i < MAX_OBJECTIVES; i++) begin
      if (OBJ_W'(i) == fi) begin
        dig_nxt[i] = '0;
      end else if (M_W'(i) == (M_W'(fi) + M_W'(1))) begin
        dig_nxt[i] = dig_r[i] + DIG_W'(1);
      end else begin
        dig_nxt[i] = dig_r[i];
      end
    end
    dig_nxt[0] = tval - DIG_W'(1);
  end

  // item checks
  always_comb begin
    if (!built_r) begin
      err = STAT_UNBUILT;
    end else if ((16'(item_r.vector_index) >= 16'(bc_r)) ||
                 ((item_r.operation == OP_READ) &&
                  (8'(item_r.objective_index) >= 8'(m_eff)))) begin
      err = STAT_RANGE;
    end else begin
      err = STAT_OK;
    end
    mismatch = pop_bad || ({1'b0, pop_r} != tot_r);
  end

  assign out_free = !out_valid_r || out_ready;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.op         = item_r.operation;
    sts.err        = err;
    sts.wr_en      = wr_en;
    sts.c_last     = c_last;
    sts.j_last     = j_last;
    sts.k_last     = k_last;
    sts.layer_done = lay_done;
    sts.tot_full   = tot_r == (TOT_LIMIT - TOT_W'(1));
    sts.inner_next = !is_inner_r && (inner_r != '0);
    sts.out_free   = out_free;
  end

  // weight memory ports
  assign vi_base = ADDR_W'(item_r.vector_index) * ADDR_W'(MAX_OBJECTIVES);
  assign w_we    = cmd.b_write && wr_en;
  assign w_waddr = ADDR_W'(vcnt_r) * ADDR_W'(MAX_OBJECTIVES) + ADDR_W'(c_r);
  assign w_wdata = WGT_W'(WV_W'(dig_r[c_r]) * WV_W'(is_inner_r ? s_in_r : s_out_r) +
                          (is_inner_r ? WV_W'(off_r) : WV_W'(0)));
  assign w_re    = cmd.rd_vi || cmd.q_issue || cmd.d_issue;

  always_comb begin
    if (cmd.d_issue) begin
      w_raddr = ADDR_W'(j_r) * ADDR_W'(MAX_OBJECTIVES) + ADDR_W'(c_r);
    end else if (cmd.q_issue) begin
      w_raddr = vi_base + ADDR_W'(c_r);
    end else begin
      w_raddr = vi_base + ADDR_W'(item_r.objective_index);
    end
  end

  swnn_ram #(
    .WIDTH (WGT_W),
    .DEPTH (MAX_VECTORS * MAX_OBJECTIVES)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // distance memory, one entry per stored vector
  assign acc_sum = acc_r + DW'(sq_r);

  swnn_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VECTORS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (cmd.d_acc && c_last),
    .waddr (j_r),
    .wdata (acc_sum),
    .re    (cmd.s_issue),
    .raddr (j_r),
    .rdata (d_rdata)
  );

  // absolute component difference
  assign absd = (w_rdata >= qv_r[c_r]) ? (w_rdata - qv_r[c_r]) : (qv_r[c_r] - w_rdata);

  // candidate ranks after the previous result
  assign after = (k_r == '0) || (d_rdata > pd_r) || ((d_rdata == pd_r) && (j_r > pi_r));

  // configuration and build status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r   <= POP_RST;
      obj_r   <= OBJ_RST;
      outer_r <= OUTER_RST;
      inner_r <= INNER_RST;
      nbr_r   <= NBR_RST;
      built_r <= 1'b0;
      bc_r    <= '0;
    end else begin
      if (cmd.commit) begin
        built_r <= 1'b1;
        bc_r    <= vcnt_r;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_POPULATION: begin
            pop_r   <= cfg_wdata;
            built_r <= 1'b0;
          end
          CFG_OBJECTIVES: begin
            obj_r   <= cfg_wdata[OBJ_CFG_W-1:0];
            built_r <= 1'b0;
          end
          CFG_OUTER: begin
            outer_r <= cfg_wdata[DIV_W-1:0];
            built_r <= 1'b0;
          end
          CFG_INNER: begin
            inner_r <= cfg_wdata[DIV_W-1:0];
            built_r <= 1'b0;
          end
          CFG_NEIGHBORS: begin
            nbr_r <= cfg_wdata[NBR_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // derived scale factors and denominator, one product per stage
  always_ff @(posedge clk) begin
    p1_r    <= (2*DIV_W)'(outer_eff) * (2*DIV_W)'(in_eff);
    den_r   <= (DEN_W'(p1_r) * DEN_W'(m_eff)) << 1;
    s_out_r <= (SCL_W'(in_eff) * SCL_W'(m_eff)) << 1;
    s_in_r  <= SCL_W'(m_eff) * SCL_W'(outer_eff);
    off_r   <= SCL_W'(inner_r) * SCL_W'(outer_eff);
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  // lattice enumeration
  always_ff @(posedge clk) begin
    if (cmd.b_init || cmd.b_inner) begin
      for (int i = 0; i < MAX_OBJECTIVES; i++) begin
        dig_r[i] <= (i == 0) ? (cmd.b_inner ? inner_r : outer_eff) : '0;
      end
      is_inner_r <= cmd.b_inner;
    end else if (cmd.b_step) begin
      dig_r <= dig_nxt;
    end
    if (cmd.b_init) begin
      tot_r  <= '0;
      vcnt_r <= '0;
    end else if (cmd.b_step) begin
      tot_r <= tot_r + TOT_W'(1);
      if (wr_en) begin
        vcnt_r <= vcnt_r + CNT_W'(1);
      end
    end
  end

  // loop counters and distance accumulation
  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.b_init || cmd.b_inner || cmd.b_step) begin
      c_r <= '0;
    end else if (cmd.b_write || cmd.q_load || cmd.d_acc) begin
      c_r <= c_last ? OBJ_W'(0) : c_r + OBJ_W'(1);
    end
    if (cmd.clr) begin
      j_r <= '0;
    end else if ((cmd.d_acc && c_last) || cmd.s_cmp) begin
      j_r <= j_last ? VEC_W'(0) : j_r + VEC_W'(1);
    end
    if (cmd.clr) begin
      k_r <= '0;
    end else if (cmd.s_next) begin
      k_r <= k_r + KW'(1);
    end
    if (cmd.q_load) begin
      qv_r[c_r] <= w_rdata;
    end
    if (cmd.d_sq) begin
      sq_r <= absd * absd;
    end
    if (cmd.clr || (cmd.d_acc && c_last)) begin
      acc_r <= '0;
    end else if (cmd.d_acc) begin
      acc_r <= acc_sum;
    end
  end

  // nearest candidate search
  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.s_next) begin
      found_r <= 1'b0;
    end else if (cmd.s_cmp && after && (!found_r || (d_rdata < bd_r))) begin
      found_r <= 1'b1;
    end
    if (cmd.s_cmp && after && (!found_r || (d_rdata < bd_r))) begin
      bd_r <= d_rdata;
      bi_r <= j_r;
    end
    if (cmd.s_next) begin
      pd_r <= bd_r;
      pi_r <= bi_r;
    end
  end

  // result beat assembly
  always_comb begin
    emit_data                    = '0;
    emit_data.status             = STAT_OK;
    emit_data.weight_denominator = 16'(den_r);
    emit_data.last               = 1'b1;
    case (cmd.emit)
      EM_BUILD: emit_data.status = mismatch ? STAT_MISMATCH : STAT_OK;
      EM_ERR:   emit_data.status = err;
      EM_READ:  emit_data.weight_numerator = w_rdata;
      EM_NEIGH: begin
        emit_data.neighbor_index   = 8'(bi_r);
        emit_data.distance_squared = DIST_OUT_W'(bd_r);
        emit_data.last             = k_last;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      out_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/swnn_ctrl.sv -----
// ---------------------------------------------------------------------------
// swnn_ctrl: sequencing state machine
// Steps the datapath through lattice build, weight read, distance table
// fill and the ranked neighbor search.
// ---------------------------------------------------------------------------
module swnn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swnn_pkg::ctl_sts_t sts,
  output swnn_pkg::ctl_cmd_t cmd
);

  import swnn_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EM_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SETTLE;
        end
      end
      // lets derived constants follow a fresh register write
      S_SETTLE: state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        cmd.clr = 1'b1;
        case (sts.op)
          OP_BUILD: state_nxt = S_B_INIT;
          OP_READ: begin
            state_nxt = (sts.err != STAT_OK) ? S_ERR_EMIT : S_RD_ISSUE;
          end
          OP_NEIGHBORS: begin
            state_nxt = (sts.err != STAT_OK) ? S_ERR_EMIT : S_Q_ISSUE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // lattice build
      S_B_INIT: begin
        cmd.b_init = 1'b1;
        state_nxt  = S_B_WRITE;
      end
      S_B_WRITE: begin
        cmd.b_write = 1'b1;
        if (sts.c_last || !sts.wr_en) begin
          state_nxt = S_B_STEP;
        end
      end
      S_B_STEP: begin
        cmd.b_step = 1'b1;
        if (sts.tot_full) begin
          state_nxt = S_B_DONE;
        end else if (sts.layer_done) begin
          state_nxt = sts.inner_next ? S_B_INNER : S_B_DONE;
        end else begin
          state_nxt = S_B_WRITE;
        end
      end
      S_B_INNER: begin
        cmd.b_inner = 1'b1;
        state_nxt   = S_B_WRITE;
      end
      S_B_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = EM_BUILD;
          state_nxt  = S_IDLE;
        end
      end
      // weight read
      S_RD_ISSUE: begin
        cmd.rd_vi = 1'b1;
        state_nxt = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = EM_READ;
          state_nxt = S_IDLE;
        end
      end
      S_ERR_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = EM_ERR;
          state_nxt = S_IDLE;
        end
      end
      // query vector load
      S_Q_ISSUE: begin
        cmd.q_issue = 1'b1;
        state_nxt   = S_Q_LOAD;
      end
      S_Q_LOAD: begin
        cmd.q_load = 1'b1;
        state_nxt  = sts.c_last ? S_D_ISSUE : S_Q_ISSUE;
      end
      // distance table fill
      S_D_ISSUE: begin
        cmd.d_issue = 1'b1;
        state_nxt   = S_D_SQ;
      end
      S_D_SQ: begin
        cmd.d_sq  = 1'b1;
        state_nxt = S_D_ACC;
      end
      S_D_ACC: begin
        cmd.d_acc = 1'b1;
        state_nxt = (sts.c_last && sts.j_last) ? S_S_ISSUE : S_D_ISSUE;
      end
      // one search pass per ranked result
      S_S_ISSUE: begin
        cmd.s_issue = 1'b1;
        state_nxt   = S_S_CMP;
      end
      S_S_CMP: begin
        cmd.s_cmp = 1'b1;
        state_nxt = sts.j_last ? S_S_EMIT : S_S_ISSUE;
      end
      S_S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = EM_NEIGH;
          cmd.s_next = 1'b1;
          state_nxt  = sts.k_last ? S_IDLE : S_S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
